[rtl/qbf_pkg.sv]
// Shared types, codes and constants of the quadratic Bezier flattener.
package qbf_pkg;

    localparam int QBF_COORD_BITS  = 28;
    localparam int QBF_MAX_DEPTH   = 5;
    localparam int QBF_ACTION_BITS = 2;
    localparam int QBF_TOL_BITS    = 28;
    localparam logic [QBF_TOL_BITS-1:0] QBF_TOL_RESET = 28'd5120;

    typedef enum logic [QBF_ACTION_BITS-1:0] {
        ACT_MOVE  = 2'd0,
        ACT_LINE  = 2'd1,
        ACT_CURVE = 2'd2
    } qbf_action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MID,
        ST_QUAD,
        ST_DIST,
        ST_DECIDE,
        ST_EMIT_Q,
        ST_EMIT_E
    } qbf_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take the item fields into the working registers
        logic set_cur;   // anchor becomes the current point
        logic mid;       // chord midpoint
        logic quad;      // curve midpoint and its offset from the chord midpoint
        logic dist_sum;  // L1 distance
        logic split;     // push the right half, continue with the left half
        logic emit_q;    // issue the curve midpoint
        logic emit_e;    // issue the end point, pop if the stack holds more
    } qbf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic flat;         // piece is flat enough or depth is saturated
        logic stack_empty;  // no right halves pending
        logic out_free;     // output register can take a vertex this cycle
    } qbf_status_t;

endpackage

[rtl/quadratic_bezier_flattener_unit.sv]
// Top level of the quadratic Bezier flattener: controller, datapath and stream ports.
// Move: the input is ready again in the cycle after the transfer. Line: its vertex
// is registered in ST_EMIT_E once the output register is free, then the input reopens.
// Curve: each subdivision node passes the midpoint, curve midpoint, distance and
// decide steps of the shared datapath, each flat piece then issues its two vertices;
// a split down to depth 5 has 63 nodes and 32 pieces. Output stalls hold vertex steps.
// Reset (aresetn low, synchronous) clears the current point, the stack, the output
// valid and sets the tolerance to 20.0; the stack entries themselves are not cleared.
module quadratic_bezier_flattener_unit
    import qbf_pkg::*;
#(
    parameter int COORD_BITS = QBF_COORD_BITS,
    parameter int MAX_DEPTH  = QBF_MAX_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Tolerance register, written whenever the enable is high
    input  logic                            cfg_wr_en,
    input  logic [QBF_TOL_BITS-1:0]         cfg_wr_data,
    // Path item input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, from bit 0: control_x, control_y, anchor_x, anchor_y, zero fill
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: action
    input  logic [QBF_ACTION_BITS-1:0]      s_tuser,
    // Polyline vertex output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, from bit 0: point_x, point_y, zero fill
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // m_tlast: last_point, final vertex caused by one input transfer
    output logic                            m_tlast
);

    localparam int CB       = COORD_BITS;
    localparam int M_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

    qbf_cmd_t      cmd;
    qbf_status_t   status;
    logic [CB-1:0] point_x, point_y;

    // Sequence the work of one item at a time
    qbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (qbf_action_t'(s_tuser)),
        .status   (status),
        .cmd      (cmd)
    );

    // Unpack the item fields straight into the datapath; it holds them on load
    qbf_datapath #(
        .COORD_BITS (COORD_BITS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .control_x   (s_tdata[CB-1:0]),
        .control_y   (s_tdata[2*CB-1:CB]),
        .anchor_x    (s_tdata[3*CB-1:2*CB]),
        .anchor_y    (s_tdata[4*CB-1:3*CB]),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .point_x     (point_x),
        .point_y     (point_y),
        .m_tlast     (m_tlast)
    );

    // Pack the vertex, zero fill to whole bytes
    assign m_tdata = M_DATA_W'({point_y, point_x});

endmodule

[rtl/qbf_ctrl.sv]
// Sequencing state machine of the quadratic Bezier flattener.
module qbf_ctrl
    import qbf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  qbf_action_t action,
    input  qbf_status_t status,
    output qbf_cmd_t    cmd
);

    qbf_state_t state_reg;
    qbf_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    case (action)
                        ACT_MOVE: begin
                            cmd.set_cur = 1'b1;
                        end
                        ACT_LINE: begin
                            cmd.set_cur = 1'b1;
                            state_next  = ST_EMIT_E;
                        end
                        ACT_CURVE: begin
                            cmd.set_cur = 1'b1;
                            state_next  = ST_MID;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MID: begin
                cmd.mid    = 1'b1;
                state_next = ST_QUAD;
            end
            ST_QUAD: begin
                cmd.quad   = 1'b1;
                state_next = ST_DIST;
            end
            ST_DIST: begin
                cmd.dist_sum = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (status.flat) begin
                    state_next = ST_EMIT_Q;
                end else begin
                    cmd.split  = 1'b1;
                    state_next = ST_MID;
                end
            end
            ST_EMIT_Q: begin
                if (status.out_free) begin
                    cmd.emit_q = 1'b1;
                    state_next = ST_EMIT_E;
                end
            end
            ST_EMIT_E: begin
                if (status.out_free) begin
                    cmd.emit_e = 1'b1;
                    state_next = status.stack_empty ? ST_IDLE : ST_MID;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/qbf_datapath.sv]
// Coordinate registers, subdivision stack, flatness test and output register.
module qbf_datapath
    import qbf_pkg::*;
#(
    parameter int COORD_BITS = QBF_COORD_BITS,
    parameter int MAX_DEPTH  = QBF_MAX_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [QBF_TOL_BITS-1:0] cfg_wr_data,
    input  logic [COORD_BITS-1:0]   control_x,
    input  logic [COORD_BITS-1:0]   control_y,
    input  logic [COORD_BITS-1:0]   anchor_x,
    input  logic [COORD_BITS-1:0]   anchor_y,
    input  qbf_cmd_t                cmd,
    output qbf_status_t             status,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic [COORD_BITS-1:0]   point_x,
    output logic [COORD_BITS-1:0]   point_y,
    output logic                    m_tlast
);

    localparam int CB    = COORD_BITS;
    localparam int TOP_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CMP_W = (CB + 1 > QBF_TOL_BITS) ? CB + 1 : QBF_TOL_BITS;

    // floor((a + b) / 2), exact at one extra bit
    function automatic logic [CB-1:0] half_sum(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB:0] s;
        s = {a[CB-1], a} + {b[CB-1], b};
        return s[CB:1];
    endfunction

    // m - floor((m + c) / 2) = ceil((m - c) / 2), one bit wider than a coordinate
    function automatic logic [CB:0] half_diff(input logic [CB-1:0] m, input logic [CB-1:0] c);
        logic [CB+1:0] t;
        t = {{2{m[CB-1]}}, m} - {{2{c[CB-1]}}, c} + (CB + 2)'(1);
        return t[CB+1:1];
    endfunction

    function automatic logic [CB:0] mag(input logic [CB:0] v);
        return v[CB] ? (~v + (CB + 1)'(1)) : v;
    endfunction

    logic [QBF_TOL_BITS-1:0] tol_reg;
    logic [CB-1:0] cur_x_reg, cur_y_reg;
    logic [CB-1:0] p0_x_reg, p0_y_reg, p1_x_reg, p1_y_reg, p2_x_reg, p2_y_reg;
    logic [CB-1:0] m_x_reg, m_y_reg, q_x_reg, q_y_reg;
    logic [CB:0]   d_x_reg, d_y_reg, dist_reg;
    logic [TOP_W-1:0] level_reg, top_reg;
    logic [CB-1:0] stk_cx [MAX_DEPTH];
    logic [CB-1:0] stk_cy [MAX_DEPTH];
    logic [CB-1:0] stk_ex [MAX_DEPTH];
    logic [CB-1:0] stk_ey [MAX_DEPTH];
    logic [TOP_W-1:0] stk_lvl [MAX_DEPTH];
    logic          out_valid_reg, out_last_reg;
    logic [CB-1:0] out_x_reg, out_y_reg;
    logic [TOP_W-1:0] top_dec;
    logic [IDX_W-1:0] push_idx, pop_idx;
    logic          stack_empty;

    assign top_dec     = top_reg - TOP_W'(1);
    assign push_idx    = top_reg[IDX_W-1:0];
    assign pop_idx     = top_dec[IDX_W-1:0];
    assign stack_empty = (top_reg == '0);

    assign status.flat = (CMP_W'(dist_reg) < CMP_W'(tol_reg))
                       || (level_reg >= TOP_W'(MAX_DEPTH))
                       || (top_reg >= TOP_W'(MAX_DEPTH));
    assign status.stack_empty = stack_empty;
    assign status.out_free    = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= QBF_TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
        end else if (cmd.set_cur) begin
            cur_x_reg <= anchor_x;
            cur_y_reg <= anchor_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg <= '0;
        end else if (cmd.load) begin
            top_reg <= '0;
        end else if (cmd.split) begin
            top_reg <= top_reg + TOP_W'(1);
        end else if (cmd.emit_e && !stack_empty) begin
            top_reg <= top_dec;
        end
    end

    // Working piece: start, control and end point with its depth
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            p0_x_reg  <= cur_x_reg;
            p0_y_reg  <= cur_y_reg;
            p1_x_reg  <= control_x;
            p1_y_reg  <= control_y;
            p2_x_reg  <= anchor_x;
            p2_y_reg  <= anchor_y;
            level_reg <= '0;
        end else if (cmd.split) begin
            p1_x_reg  <= half_sum(p0_x_reg, p1_x_reg);
            p1_y_reg  <= half_sum(p0_y_reg, p1_y_reg);
            p2_x_reg  <= q_x_reg;
            p2_y_reg  <= q_y_reg;
            level_reg <= level_reg + TOP_W'(1);
        end else if (cmd.emit_e && !stack_empty) begin
            p0_x_reg  <= p2_x_reg;
            p0_y_reg  <= p2_y_reg;
            p1_x_reg  <= stk_cx[pop_idx];
            p1_y_reg  <= stk_cy[pop_idx];
            p2_x_reg  <= stk_ex[pop_idx];
            p2_y_reg  <= stk_ey[pop_idx];
            level_reg <= stk_lvl[pop_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.split) begin
            stk_cx[push_idx]  <= half_sum(p1_x_reg, p2_x_reg);
            stk_cy[push_idx]  <= half_sum(p1_y_reg, p2_y_reg);
            stk_ex[push_idx]  <= p2_x_reg;
            stk_ey[push_idx]  <= p2_y_reg;
            stk_lvl[push_idx] <= level_reg + TOP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mid) begin
            m_x_reg <= half_sum(p0_x_reg, p2_x_reg);
            m_y_reg <= half_sum(p0_y_reg, p2_y_reg);
        end
        if (cmd.quad) begin
            q_x_reg <= half_sum(m_x_reg, p1_x_reg);
            q_y_reg <= half_sum(m_y_reg, p1_y_reg);
            d_x_reg <= half_diff(m_x_reg, p1_x_reg);
            d_y_reg <= half_diff(m_y_reg, p1_y_reg);
        end
        if (cmd.dist_sum) begin
            dist_reg <= mag(d_x_reg) + mag(d_y_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_q || cmd.emit_e) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_q) begin
            out_x_reg    <= q_x_reg;
            out_y_reg    <= q_y_reg;
            out_last_reg <= 1'b0;
        end else if (cmd.emit_e) begin
            out_x_reg    <= p2_x_reg;
            out_y_reg    <= p2_y_reg;
            out_last_reg <= stack_empty;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign point_x  = out_x_reg;
    assign point_y  = out_y_reg;
    assign m_tlast  = out_last_reg;

endmodule

[rtl/qbf_checker.sv]
// Port-level assertions for the quadratic Bezier flattener, bound to its top level.
module qbf_checker
    import qbf_pkg::*;
#(
    parameter int COORD_BITS = QBF_COORD_BITS
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [QBF_ACTION_BITS-1:0]        s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    input logic                              m_tlast
);

    // Output register empties on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Stalled vertex holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled vertex changed");

    // A move emits nothing and frees the input at once
    a_move_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_MOVE |=> s_tready)
        else $error("move held the input");

    // A line keeps the input closed while its vertex is issued
    a_line_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_LINE |=> !s_tready)
        else $error("line did not hold the input");

    // A curve keeps the input closed at least through its chord and curve midpoint steps
    a_curve_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_CURVE |=> !s_tready ##1 !s_tready)
        else $error("curve released the input early");

endmodule

bind quadratic_bezier_flattener_unit qbf_checker #(
    .COORD_BITS (COORD_BITS)
) u_qbf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
